// ===== hw/rtl/ewma_stdev_outlier_filter_defines.svh =====
// Assertion helpers shared by the filter RTL.
// Both sample on clk_i and are switched off while rst_ni is low.
`ifndef EWMA_STDEV_OUTLIER_FILTER_DEFINES_SVH
`define EWMA_STDEV_OUTLIER_FILTER_DEFINES_SVH

// Same-cycle implication.
`define ESOF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ESOF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/esof_pkg.sv =====
`timescale 1ns / 1ps

package esof_pkg;

  // Stream and configuration widths
  localparam int unsigned IN_W       = 16;
  localparam int unsigned OUT_W      = 40;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 8'd1;

  // Digit-serial multiplier: signed multiplicand, unsigned multiplier
  // consumed most significant digit first.
  localparam int unsigned DIG_W  = 4;
  localparam int unsigned MUL_W  = 32;
  localparam int unsigned MC_W   = 66;
  localparam int unsigned PROD_W = MC_W + MUL_W;
  localparam int unsigned CNT_W  = 4;

  // Digit counts for the operand sizes in use
  localparam logic [CNT_W-1:0] DIGS_12 = 4'd3;
  localparam logic [CNT_W-1:0] DIGS_16 = 4'd4;
  localparam logic [CNT_W-1:0] DIGS_24 = 4'd6;
  localparam logic [CNT_W-1:0] DIGS_32 = 4'd8;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] digits;
  } mul_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_MEAN,
    S_MSQ,
    S_MEAN2,
    S_DIFF2,
    S_LIM2,
    S_VLIM,
    S_OUT
  } state_e;

endpackage

// ===== hw/rtl/ewma_stdev_outlier_filter.sv =====
`timescale 1ns / 1ps

// Depth outlier filter with exponentially weighted mean and variance.
// Input stream (s_axis_*): one 16-bit unsigned depth sample per item.
// Output stream (m_axis_*): one result item per input item carrying the
// accept flag, the held filtered depth (-1 until a sample is accepted) and
// the integer part of the running mean.
// Configuration channel (cfg_*): index 0 writes alpha (Q0.16), index 1 the
// deviation limit (Q4.8); other indexes are ignored. Write only while idle.
// All products go through one shared 4-bit digit-serial multiplier, seven
// products per item. No new item is accepted until the previous one has
// passed all seven products and its result is in the output register.
// The result waits in an output register; a new item is taken while it
// waits, but the next result is not written until the receiver takes it,
// and no further item is accepted meanwhile.
// Reset restores the register defaults, clears mean and mean square, marks
// the next sample as the seed and sets the filtered depth to -1.

`include "ewma_stdev_outlier_filter_defines.svh"

module ewma_stdev_outlier_filter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [esof_pkg::IN_W-1:0]          s_axis_tdata,   // [15:0] depth_sample
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] accepted, [17:1] filtered_depth, [33:18] mean_depth, [39:34] zero
  output logic [esof_pkg::OUT_W-1:0]         m_axis_tdata,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [esof_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [esof_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import esof_pkg::*;

  localparam logic [16:0] FILT_NONE = 17'h1FFFF;

  state_e state_q, state_d;
  logic   go_q, go_d;

  mul_cmd_t                 cmd;
  mul_sts_t                 sts;
  logic signed [MC_W-1:0]   mc;
  logic [MUL_W-1:0]         mult;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;

  // Configuration and filter state
  logic [15:0] alpha_q;
  logic [11:0] lim_q;
  logic [31:0] mean_q;
  logic [47:0] msq_q;
  logic        first_q;
  logic [16:0] held_q;

  // Per-item working registers
  logic [15:0] d_q;
  logic [31:0] sq_q;
  logic [63:0] var_q;
  logic        var_ok_q;
  logic [31:0] diff_q;
  logic [63:0] diff2_q;
  logic [23:0] lim2_q;
  logic        ok_q;

  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  logic               in_acc;
  logic               out_free;
  logic signed [32:0] mdiff;
  logic signed [48:0] qdiff;
  logic [64:0]        vsub;
  logic [31:0]        dfix;
  logic [31:0]        absdiff;
  logic               ok;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  assign mdiff   = $signed({1'b0, d_q, 16'h0000}) - $signed({1'b0, mean_q});
  assign qdiff   = $signed({1'b0, sq_q, 16'h0000}) - $signed({1'b0, msq_q});
  assign prod_sh = prod >>> 16;
  assign vsub    = {1'b0, msq_q, 16'h0000} - {1'b0, prod[63:0]};
  assign dfix    = {d_q, 16'h0000};
  assign absdiff = (mean_q >= dfix) ? (mean_q - dfix) : (dfix - mean_q);
  assign ok      = var_ok_q && ({8'h00, diff2_q, 16'h0000} <= prod[87:0]);

  esof_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .mc_i   (mc),
    .mult_i (mult),
    .sts_o  (sts),
    .prod_o (prod)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    go_d    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_SQ;
          go_d    = 1'b1;
        end
      end
      S_SQ: begin
        if (sts.done) begin
          state_d = S_MEAN;
          go_d    = 1'b1;
        end
      end
      S_MEAN: begin
        if (sts.done) begin
          state_d = S_MSQ;
          go_d    = 1'b1;
        end
      end
      S_MSQ: begin
        if (sts.done) begin
          state_d = S_MEAN2;
          go_d    = 1'b1;
        end
      end
      S_MEAN2: begin
        if (sts.done) begin
          state_d = S_DIFF2;
          go_d    = 1'b1;
        end
      end
      S_DIFF2: begin
        if (sts.done) begin
          state_d = S_LIM2;
          go_d    = 1'b1;
        end
      end
      S_LIM2: begin
        if (sts.done) begin
          state_d = S_VLIM;
          go_d    = 1'b1;
        end
      end
      S_VLIM: begin
        if (sts.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs: handshake and multiplier operands
  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    cmd.start     = go_q;
    cmd.digits    = DIGS_16;
    mc            = '0;
    mult          = '0;
    case (state_q)
      S_SQ: begin
        mc   = MC_W'(d_q);
        mult = {d_q, 16'h0000};
      end
      S_MEAN: begin
        mc   = MC_W'(mdiff);
        mult = {alpha_q, 16'h0000};
      end
      S_MSQ: begin
        mc   = MC_W'(qdiff);
        mult = {alpha_q, 16'h0000};
      end
      S_MEAN2: begin
        cmd.digits = DIGS_32;
        mc         = MC_W'(mean_q);
        mult       = mean_q;
      end
      S_DIFF2: begin
        cmd.digits = DIGS_32;
        mc         = MC_W'(diff_q);
        mult       = diff_q;
      end
      S_LIM2: begin
        cmd.digits = DIGS_12;
        mc         = MC_W'(lim_q);
        mult       = {lim_q, 20'h00000};
      end
      S_VLIM: begin
        cmd.digits = DIGS_24;
        mc         = MC_W'(var_q);
        mult       = {lim2_q, 8'h00};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= go_d;
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 16'd6554;
      lim_q   <= 12'd768;
      mean_q  <= '0;
      msq_q   <= '0;
      first_q <= 1'b1;
      held_q  <= FILT_NONE;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ALPHA: alpha_q <= cfg_data_i[15:0];
          CFG_LIMIT: lim_q   <= cfg_data_i[11:0];
          default: ;
        endcase
      end
      case (state_q)
        S_SQ: begin
          // seed both averages from the first sample
          if (sts.done && first_q) begin
            mean_q  <= {d_q, 16'h0000};
            msq_q   <= {prod[31:0], 16'h0000};
            first_q <= 1'b0;
          end
        end
        S_MEAN: begin
          if (sts.done) begin
            mean_q <= mean_q + prod_sh[31:0];
          end
        end
        S_MSQ: begin
          if (sts.done) begin
            msq_q <= msq_q + prod_sh[47:0];
          end
        end
        S_VLIM: begin
          if (sts.done && ok) begin
            held_q <= {1'b0, d_q};
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          d_q <= s_axis_tdata;
        end
      end
      S_SQ: begin
        if (sts.done) begin
          sq_q <= prod[31:0];
        end
      end
      S_MEAN2: begin
        // negative variance rejects the sample outright
        if (sts.done) begin
          var_q    <= vsub[63:0];
          var_ok_q <= !vsub[64];
          diff_q   <= absdiff;
        end
      end
      S_DIFF2: begin
        if (sts.done) begin
          diff2_q <= prod[63:0];
        end
      end
      S_LIM2: begin
        if (sts.done) begin
          lim2_q <= prod[23:0];
        end
      end
      S_VLIM: begin
        if (sts.done) begin
          ok_q <= ok;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_data_q <= {(OUT_W - 34)'(0), mean_q[31:16], held_q, ok_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  `ESOF_ASSERT_IMP(a_accept_mul_idle, in_acc, !sts.busy, "item taken while multiplier busy")
  `ESOF_ASSERT_IMP(a_held_none, held_q[16], held_q == FILT_NONE, "bad held depth")
  `ESOF_ASSERT_IMP(a_seed_in_sq, $fell(first_q), $past(state_q) == S_SQ, "seed cleared outside SQ")

endmodule

// ===== hw/rtl/esof_mul.sv =====
`timescale 1ns / 1ps

`include "ewma_stdev_outlier_filter_defines.svh"

module esof_mul (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  esof_pkg::mul_cmd_t                     cmd_i,
  input  logic signed [esof_pkg::MC_W-1:0]       mc_i,
  input  logic        [esof_pkg::MUL_W-1:0]      mult_i,  // left-aligned
  output esof_pkg::mul_sts_t                     sts_o,
  output logic signed [esof_pkg::PROD_W-1:0]     prod_o
);
  import esof_pkg::*;

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [MC_W-1:0]   mc_q;
  logic [MUL_W-1:0]         mult_q;
  logic signed [PROD_W-1:0] acc_q;

  logic [DIG_W-1:0]           digit;
  logic signed [MC_W+DIG_W:0] pp;
  logic signed [PROD_W-1:0]   acc_d;

  assign digit = mult_q[MUL_W-1 -: DIG_W];
  assign pp    = (MC_W+DIG_W+1)'(mc_q) * (MC_W+DIG_W+1)'($signed({1'b0, digit}));
  assign acc_d = (acc_q <<< DIG_W) + PROD_W'(pp);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = cmd_i.digits;
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // While busy, shift the multiplier out one digit a cycle and fold it into the sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mc_q   <= mc_i;
      mult_q <= mult_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      mult_q <= mult_q << DIG_W;
      acc_q  <= acc_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign prod_o     = acc_q;

  `ESOF_ASSERT_IMP(a_start_idle, cmd_i.start, !busy_q, "multiply started while busy")
  `ESOF_ASSERT_NEXT(a_done_after_last, busy_q && cnt_q == CNT_W'(1), done_q, "missing done")
  `ESOF_ASSERT_IMP(a_busy_from_start, $rose(busy_q), $past(cmd_i.start), "busy without start")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  // Same bit order as m_axis_tdata, lowest field last
  typedef struct packed {
    logic [5:0]  pad;
    logic [15:0] mean_depth;
    logic [16:0] filtered_depth;
    logic        accepted;
  } filter_result_t;

  // Indexes the block must ignore
  localparam logic [esof_pkg::CFG_IDX_W-1:0] CFG_SPARE = 8'd2;
  localparam logic [esof_pkg::CFG_IDX_W-1:0] CFG_TOP   = 8'hFF;

  localparam logic [15:0] ALPHA_DEFAULT = 16'd6554;
  localparam logic [15:0] LIMIT_DEFAULT = 16'd768;
  localparam int unsigned RUNS          = 9;
  localparam int unsigned RUN_ITEMS     = 192;
  localparam int unsigned DRAIN_CYCLES  = 60;
  localparam int unsigned MAX_PRINTS    = 40;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [esof_pkg::IN_W-1:0]           s_axis_tdata = '0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [esof_pkg::OUT_W-1:0]          m_axis_tdata;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [esof_pkg::CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [esof_pkg::CFG_DATA_W-1:0]     cfg_data_i = '0;

  // Filter state as the block should hold it
  logic [15:0]        alpha_q    = ALPHA_DEFAULT;
  logic [11:0]        limit_q    = LIMIT_DEFAULT[11:0];
  logic [31:0]        mean_q     = '0;
  logic [47:0]        mean_sq_q  = '0;
  logic               seed_due   = 1'b1;
  logic signed [16:0] held_depth = -17'sd1;

  logic [15:0]    depth_pending[$];
  filter_result_t result_expect[$];
  int unsigned    idle_pct = 12;
  int unsigned    error_count = 0;
  int unsigned    result_count = 0;

  always #1 clk_i = ~clk_i;

  ewma_stdev_outlier_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Advance the weighted mean and mean square by one sample and run the
  // deviation test; the squared form avoids any square root.
  function automatic filter_result_t filter_depth(input logic [15:0] depth);
    logic [127:0]   w_new, w_old, sample_q, square_q, mean_next, sq_next;
    logic [127:0]   sq_wide, mean_pow, spread, gap, lim_sq;
    logic           pass;
    filter_result_t res;
    w_new    = {112'd0, alpha_q};
    w_old    = 128'd65536 - w_new;
    sample_q = {112'd0, depth} << 16;
    square_q = ({112'd0, depth} * {112'd0, depth}) << 16;
    if (seed_due) begin
      mean_q    = sample_q[31:0];
      mean_sq_q = square_q[47:0];
      seed_due  = 1'b0;
    end
    mean_next = (w_old * {96'd0, mean_q} + w_new * sample_q) >> 16;
    sq_next   = (w_old * {80'd0, mean_sq_q} + w_new * square_q) >> 16;
    mean_q    = mean_next[31:0];
    mean_sq_q = sq_next[47:0];
    sq_wide   = {80'd0, mean_sq_q} << 16;
    mean_pow  = {96'd0, mean_q} * {96'd0, mean_q};
    pass      = 1'b0;
    // negative variance rejects outright
    if (sq_wide >= mean_pow) begin
      spread = sq_wide - mean_pow;
      gap    = ({96'd0, mean_q} >= sample_q) ? {96'd0, mean_q} - sample_q
                                             : sample_q - {96'd0, mean_q};
      lim_sq = {116'd0, limit_q} * {116'd0, limit_q};
      pass   = ((gap * gap) << 16) <= spread * lim_sq;
    end
    if (pass) held_depth = {1'b0, depth};
    res.pad            = '0;
    res.mean_depth     = mean_q[31:16];
    res.filtered_depth = held_depth;
    res.accepted       = pass;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTS) $display("%0t mismatch: %s", $realtime, what);
  endtask

  // Sender: hold the item until taken, then load the next or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) result_expect.push_back(filter_depth(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (depth_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= depth_pending.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random and check every result item taken
  always @(posedge clk_i or negedge rst_ni) begin
    filter_result_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = filter_result_t'(m_axis_tdata);
        if (result_expect.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", result_count));
        end else begin
          want = result_expect.pop_front();
          if (got.accepted !== want.accepted)
            report_mismatch($sformatf("result %0d accepted %b, want %b",
                                      result_count, got.accepted, want.accepted));
          if (got.filtered_depth !== want.filtered_depth)
            report_mismatch($sformatf("result %0d filtered_depth %0d, want %0d", result_count,
                                      $signed(got.filtered_depth),
                                      $signed(want.filtered_depth)));
          if (got.mean_depth !== want.mean_depth)
            report_mismatch($sformatf("result %0d mean_depth %0d, want %0d",
                                      result_count, got.mean_depth, want.mean_depth));
          if (got.pad !== want.pad)
            report_mismatch($sformatf("result %0d padding %b", result_count, got.pad));
        end
        result_count++;
      end
      m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (depth_pending.size() != 0 || s_axis_tvalid || result_expect.size() != 0);
  endtask

  task automatic write_reg(input logic [esof_pkg::CFG_IDX_W-1:0] idx,
                           input logic [esof_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == esof_pkg::CFG_ALPHA) alpha_q = value;
    else if (idx == esof_pkg::CFG_LIMIT) limit_q = value[11:0];
  endtask

  // A slowly drifting depth with noise, jumps and wild spikes
  task automatic queue_depth_run(input int unsigned count);
    int level, spread, value, pick;
    level  = $urandom_range(65535);
    spread = $urandom_range(1, 300);
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        value = $urandom_range(65535);
      end else if (pick < 11) begin
        level = $urandom_range(65535);
        value = level;
      end else begin
        value = level + int'($urandom_range(2 * spread)) - spread;
        if (value < 0) value = 0;
        if (value > 65535) value = 65535;
        level = value;
      end
      depth_pending.push_back(value[15:0]);
    end
  endtask

  initial begin
    logic [15:0] alpha_pick, limit_pick;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Seed at reset settings; a repeated value keeps the variance at zero
    depth_pending.push_back(16'd1234);
    depth_pending.push_back(16'd1234);
    wait_drained();

    // Zero weight freezes the mean; zero limit passes only an exact match
    write_reg(esof_pkg::CFG_ALPHA, 16'd0);
    write_reg(esof_pkg::CFG_LIMIT, 16'd0);
    depth_pending.push_back(16'd1234);
    depth_pending.push_back(16'd1235);
    depth_pending.push_back(16'd0);
    depth_pending.push_back(16'hFFFF);
    depth_pending.push_back(16'd1234);
    wait_drained();

    write_reg(esof_pkg::CFG_ALPHA, 16'hFFFF);
    write_reg(esof_pkg::CFG_LIMIT, 16'h0FFF);
    depth_pending.push_back(16'hFFFF);
    depth_pending.push_back(16'd0);
    depth_pending.push_back(16'h5555);
    depth_pending.push_back(16'hAAAA);
    depth_pending.push_back(16'd1);
    depth_pending.push_back(16'd300);
    wait_drained();

    // Ignored indexes must leave both registers alone
    write_reg(esof_pkg::CFG_ALPHA, ALPHA_DEFAULT);
    write_reg(CFG_SPARE, 16'hFFFF);
    write_reg(esof_pkg::CFG_LIMIT, LIMIT_DEFAULT);
    write_reg(CFG_TOP, 16'h0000);
    depth_pending.push_back(16'd1000);
    depth_pending.push_back(16'd1004);
    depth_pending.push_back(16'd1003);
    depth_pending.push_back(16'd40000);
    depth_pending.push_back(16'd998);
    wait_drained();

    for (int unsigned r = 0; r < RUNS; r++) begin
      alpha_pick = (r % 3 == 0) ? 16'($urandom_range(65535))
                                : 16'($urandom_range(300, 20000));
      limit_pick = (r % 2 == 0) ? 16'($urandom_range(4095))
                                : 16'($urandom_range(128, 1280));
      if (r == RUNS - 1) limit_pick = 16'h0FFF;
      write_reg(esof_pkg::CFG_ALPHA, alpha_pick);
      write_reg(esof_pkg::CFG_LIMIT, limit_pick);
      if (r == 3) write_reg(CFG_SPARE, 16'($urandom_range(65535)));
      idle_pct = (r == 4) ? 0 : 12;
      queue_depth_run(RUN_ITEMS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (result_expect.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", result_expect.size()));
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #1500000;
    $display("testbench: errors");
    $finish;
  end

endmodule
